// ===== rtl/core/ndpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ndpd_pkg
// Item types and fixed constants shared by the numeric date prefix detector.
// ----------------------------------------------------------------------------
package ndpd_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_value;
	} byte_item_t;

	typedef struct packed {
		logic       matched;
		logic [7:0] sep_byte;
		logic       last_of_run;
	} result_item_t;

	localparam logic [7:0] PERCENT    = 8'h25;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;
	localparam logic [7:0] SPACE      = 8'h20;
	localparam logic [7:0] CTRL_WS_LO = 8'h09;
	localparam logic [7:0] CTRL_WS_HI = 8'h0D;

endpackage

// ===== rtl/core/ndpd_queue.sv =====
// ----------------------------------------------------------------------------
// ndpd_queue
// Two-entry queue of finished value descriptors between front and back.
// ----------------------------------------------------------------------------
module ndpd_queue #(
	parameter int WIDTH = 74
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             avail,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/ndpd_front.sv =====
// ----------------------------------------------------------------------------
// ndpd_front
// Classifies one byte per cycle unless stalled, holds the first literal and
// compares the second against it, and queues a descriptor when a value ends.
// ----------------------------------------------------------------------------
module ndpd_front #(
	parameter int MAX_LITERAL = 8,
	parameter int LW          = $clog2(MAX_LITERAL + 1),
	parameter int IW          = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1,
	parameter int JW          = 1 + LW + 8 * MAX_LITERAL
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  ndpd_pkg::byte_item_t byte_item,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [JW-1:0]        q_data
);

	localparam logic [2:0] PH_SPACE = 3'd0;
	localparam logic [2:0] PH_RUN1  = 3'd1;
	localparam logic [2:0] PH_LIT1  = 3'd2;
	localparam logic [2:0] PH_RUN2  = 3'd3;
	localparam logic [2:0] PH_LIT2  = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	localparam logic [1:0] V_UNDECIDED = 2'd0;
	localparam logic [1:0] V_MATCH     = 2'd1;
	localparam logic [1:0] V_NOMATCH   = 2'd2;

	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LITERAL);

	logic [MAX_LITERAL-1:0][7:0] lit_q;
	logic [2:0]                  phase_q, phase_n;
	logic [LW-1:0]               len_q, len_n;
	logic [LW-1:0]               pos_q, pos_n, pos_c;
	logic                        mism_q, mism_n, mism_c;
	logic [1:0]                  verdict_q, verdict_n;
	logic                        lit_wr;
	logic                        accept;
	logic                        dig;
	logic                        spc;
	logic [7:0]                  c;

	assign c          = byte_item.char_byte;
	assign byte_stall = q_full;
	assign accept     = byte_valid & ~q_full;
	assign q_push     = accept & byte_item.end_of_value;
	assign q_data     = {(verdict_n == V_MATCH), len_q, lit_q};

	assign dig = (c >= ndpd_pkg::DIGIT_LO) && (c <= ndpd_pkg::DIGIT_HI);
	assign spc = (c == ndpd_pkg::SPACE) ||
	             ((c >= ndpd_pkg::CTRL_WS_LO) && (c <= ndpd_pkg::CTRL_WS_HI));

	always_comb begin
		phase_n   = phase_q;
		len_n     = len_q;
		pos_n     = pos_q;
		mism_n    = mism_q;
		verdict_n = verdict_q;
		lit_wr    = 1'b0;
		pos_c     = (phase_q == PH_RUN2) ? '0 : pos_q;
		mism_c    = (phase_q == PH_RUN2) ? 1'b0 : mism_q;
		case (phase_q)
			PH_SPACE: begin
				if (dig) begin
					phase_n = PH_RUN1;
				end else if (!spc) begin
					verdict_n = V_NOMATCH;
					phase_n   = PH_DONE;
				end
			end
			PH_RUN1, PH_LIT1: begin
				if (dig) begin
					if (phase_q == PH_LIT1) begin
						phase_n = PH_RUN2;
					end
				end else if (len_q == LEN_MAX) begin
					verdict_n = V_NOMATCH;
					phase_n   = PH_DONE;
				end else begin
					lit_wr  = 1'b1;
					len_n   = len_q + 1'b1;
					phase_n = PH_LIT1;
				end
			end
			PH_RUN2, PH_LIT2: begin
				if (dig) begin
					if (phase_q == PH_LIT2) begin
						verdict_n = (!mism_q && (pos_q == len_q)) ? V_MATCH : V_NOMATCH;
						phase_n   = PH_DONE;
					end
				end else begin
					phase_n = PH_LIT2;
					// A second literal longer than the first can never match.
					if (pos_c >= len_q) begin
						mism_n = 1'b1;
						pos_n  = pos_c;
					end else begin
						mism_n = mism_c | (lit_q[pos_c[IW-1:0]] != c);
						pos_n  = pos_c + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && lit_wr) begin
			lit_q[len_q[IW-1:0]] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SPACE;
			len_q     <= '0;
			pos_q     <= '0;
			mism_q    <= 1'b0;
			verdict_q <= V_UNDECIDED;
		end else if (accept) begin
			if (byte_item.end_of_value) begin
				phase_q   <= PH_SPACE;
				len_q     <= '0;
				pos_q     <= '0;
				mism_q    <= 1'b0;
				verdict_q <= V_UNDECIDED;
			end else begin
				phase_q   <= phase_n;
				len_q     <= len_n;
				pos_q     <= pos_n;
				mism_q    <= mism_n;
				verdict_q <= verdict_n;
			end
		end
	end

endmodule

// ===== rtl/core/ndpd_back.sv =====
// ----------------------------------------------------------------------------
// ndpd_back
// Turns one queued descriptor into result items: a single no-match item, or
// the separator bytes with each percent sign doubled.
// ----------------------------------------------------------------------------
module ndpd_back #(
	parameter int MAX_LITERAL = 8,
	parameter int LW          = $clog2(MAX_LITERAL + 1),
	parameter int IW          = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1,
	parameter int JW          = 1 + LW + 8 * MAX_LITERAL
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_avail,
	input  logic [JW-1:0]          q_head,
	output logic                   q_pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ndpd_pkg::result_item_t result_item
);

	logic                        cur_valid_q;
	logic                        cur_matched_q;
	logic [LW-1:0]               cur_len_q;
	logic [MAX_LITERAL-1:0][7:0] cur_lit_q;
	logic [IW-1:0]               idx_q;
	logic                        dup_q;
	logic                        res_valid_q;
	ndpd_pkg::result_item_t      res_item_q;
	ndpd_pkg::result_item_t      res_n;

	logic       go;
	logic       done;
	logic       load;
	logic [7:0] b;
	logic       pct_first;
	logic       last_byte;

	assign b         = cur_lit_q[idx_q];
	assign pct_first = (b == ndpd_pkg::PERCENT) && !dup_q;
	assign last_byte = ((LW'(idx_q) + 1'b1) == cur_len_q);
	assign go        = cur_valid_q & (~res_valid_q | ~result_stall);
	assign done      = go & (~cur_matched_q | (~pct_first & last_byte));
	assign load      = (~cur_valid_q | done) & q_avail;
	assign q_pop     = load;

	assign result_valid = res_valid_q;
	assign result_item  = res_item_q;

	always_comb begin
		if (!cur_matched_q) begin
			res_n.matched     = 1'b0;
			res_n.sep_byte    = 8'h00;
			res_n.last_of_run = 1'b1;
		end else begin
			res_n.matched     = 1'b1;
			res_n.sep_byte    = b;
			res_n.last_of_run = ~pct_first & last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_matched_q <= q_head[JW-1];
			cur_len_q     <= q_head[JW-2 -: LW];
			cur_lit_q     <= q_head[8*MAX_LITERAL-1:0];
		end
		if (go) begin
			res_item_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			dup_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end

			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end

			if (load) begin
				idx_q <= '0;
				dup_q <= 1'b0;
			end else if (go && cur_matched_q) begin
				// A percent sign goes out twice; the first copy holds the index.
				if (pct_first) begin
					dup_q <= 1'b1;
				end else begin
					dup_q <= 1'b0;
					idx_q <= IW'(idx_q + 1'b1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/numeric_date_prefix_detector.sv =====
// A value's descriptor passes through the queue and the emitter's descriptor
// register before its first result item is registered on the output.
// Throughput, unless stalled: one byte per cycle in, one result item per cycle out.
// A two-entry descriptor queue lets the byte classifier run ahead of the emitter.
// Reset (arst_n low) clears all control state; the literal storage is not reset.
// ----------------------------------------------------------------------------
// numeric_date_prefix_detector
// Detects a numeric date prefix in a field value and reports its separator.
// ----------------------------------------------------------------------------
module numeric_date_prefix_detector #(
	parameter int MAX_LITERAL = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  ndpd_pkg::byte_item_t   byte_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ndpd_pkg::result_item_t result_item
);

	localparam int LW = $clog2(MAX_LITERAL + 1);
	localparam int IW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
	localparam int JW = 1 + LW + 8 * MAX_LITERAL;

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_avail;
	logic [JW-1:0] q_data;
	logic [JW-1:0] q_head;

	ndpd_front #(
		.MAX_LITERAL(MAX_LITERAL),
		.LW         (LW),
		.IW         (IW),
		.JW         (JW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	ndpd_queue #(
		.WIDTH(JW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.pop      (q_pop),
		.full     (q_full),
		.avail    (q_avail),
		.head     (q_head)
	);

	ndpd_back #(
		.MAX_LITERAL(MAX_LITERAL),
		.LW         (LW),
		.IW         (IW),
		.JW         (JW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_avail     (q_avail),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

endmodule

// ===== sim/tb_numeric_date_prefix_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_numeric_date_prefix_detector
// Streams field values into the date prefix detector byte by byte. A
// scoreboard tracks the value scan and queues the escaped separator items
// that each final byte should produce. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_numeric_date_prefix_detector;

	localparam int MAX_LITERAL = 8;

	typedef enum logic [2:0] {
		SCAN_SPACE, SCAN_RUN1, SCAN_LIT1, SCAN_RUN2, SCAN_LIT2, SCAN_DONE
	} scan_phase_t;

	typedef enum logic [1:0] {
		VERDICT_OPEN, VERDICT_MATCH, VERDICT_NOMATCH
	} verdict_t;

	class separator_board;
		scan_phase_t            phase;
		verdict_t               verdict;
		logic [7:0]             lit [MAX_LITERAL];
		int unsigned            lit_len;
		int unsigned            cmp_pos;
		bit                     cmp_bad;
		ndpd_pkg::result_item_t pending_seps[$];
		int unsigned            errors;
		int unsigned            predicted;

		function new();
			errors = 0;
			predicted = 0;
			clear_value();
		endfunction

		function void clear_value();
			phase = SCAN_SPACE;
			verdict = VERDICT_OPEN;
			lit_len = 0;
			cmp_pos = 0;
			cmp_bad = 1'b0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= ndpd_pkg::DIGIT_LO && c <= ndpd_pkg::DIGIT_HI;
		endfunction

		function bit is_space(logic [7:0] c);
			return c == ndpd_pkg::SPACE ||
				(c >= ndpd_pkg::CTRL_WS_LO && c <= ndpd_pkg::CTRL_WS_HI);
		endfunction

		function void decide(verdict_t v);
			verdict = v;
			phase = SCAN_DONE;
		endfunction

		function void push_sep(logic m, logic [7:0] b, logic fin);
			ndpd_pkg::result_item_t r;
			r.matched = m;
			r.sep_byte = b;
			r.last_of_run = fin;
			pending_seps = {pending_seps, r};
			predicted++;
		endfunction

		function void note_byte(ndpd_pkg::byte_item_t it);
			logic [7:0] c;
			bit dig;
			c = it.char_byte;
			dig = is_digit(c);
			case (phase)
				SCAN_SPACE: begin
					if (dig)
						phase = SCAN_RUN1;
					else if (!is_space(c))
						decide(VERDICT_NOMATCH);
				end
				SCAN_RUN1, SCAN_LIT1: begin
					if (dig) begin
						if (phase == SCAN_LIT1)
							phase = SCAN_RUN2;
					end else if (lit_len >= MAX_LITERAL) begin
						decide(VERDICT_NOMATCH);
					end else begin
						lit[lit_len] = c;
						lit_len++;
						phase = SCAN_LIT1;
					end
				end
				SCAN_RUN2, SCAN_LIT2: begin
					if (dig) begin
						if (phase == SCAN_LIT2)
							decide((!cmp_bad && cmp_pos == lit_len) ?
								VERDICT_MATCH : VERDICT_NOMATCH);
					end else begin
						// A new second literal restarts the compare.
						if (phase == SCAN_RUN2) begin
							cmp_pos = 0;
							cmp_bad = 1'b0;
							phase = SCAN_LIT2;
						end
						if (cmp_pos >= lit_len) begin
							cmp_bad = 1'b1;
						end else begin
							if (lit[cmp_pos] != c)
								cmp_bad = 1'b1;
							cmp_pos++;
						end
					end
				end
				default: ;
			endcase
			if (!it.end_of_value)
				return;
			if (verdict != VERDICT_MATCH) begin
				push_sep(1'b0, 8'h00, 1'b1);
			end else begin
				for (int unsigned i = 0; i < lit_len; i++) begin
					if (lit[i] == ndpd_pkg::PERCENT)
						push_sep(1'b1, lit[i], 1'b0);
					push_sep(1'b1, lit[i], i + 1 == lit_len);
				end
			end
			clear_value();
		endfunction

		function void check_sep(ndpd_pkg::result_item_t got);
			ndpd_pkg::result_item_t want;
			if (pending_seps.size() == 0) begin
				$display("%0t: result item expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_seps.pop_front();
			if (got.matched !== want.matched) begin
				$display("%0t: matched expected %b actual %b", $time, want.matched,
					got.matched);
				errors++;
			end
			if (got.sep_byte !== want.sep_byte) begin
				$display("%0t: sep_byte expected %h actual %h", $time, want.sep_byte,
					got.sep_byte);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$display("%0t: last_of_run expected %b actual %b", $time,
					want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_seps.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_stall;
	ndpd_pkg::byte_item_t   byte_item;
	logic                   result_valid;
	logic                   result_stall;
	ndpd_pkg::result_item_t result_item;

	separator_board board;
	int unsigned bytes_sent;
	bit          tx_burst;
	bit          rx_burst;

	numeric_date_prefix_detector #(
		.MAX_LITERAL(MAX_LITERAL)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Result side: each accepted item is followed by a drawn stall stretch, or none in a burst.
	initial begin
		int stall_left;
		stall_left = 0;
		rx_burst = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				board.check_sep(result_item);
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				stall_left = rx_burst ? 0 : $urandom_range(0, 18);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_stall <= (stall_left > 0);
		end
	end

	function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] c);
		q = {q, c};
	endfunction

	task automatic send_byte(input logic [7:0] c, input bit fin);
		int gap;
		ndpd_pkg::byte_item_t it;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		it.char_byte = c;
		it.end_of_value = fin;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (byte_stall);
		board.note_byte(it);
		bytes_sent++;
	endtask

	task automatic send_value(input logic [7:0] v[$]);
		tx_burst = ($urandom_range(0, 3) == 0);
		foreach (v[i])
			send_byte(v[i], i == v.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] v[$];
		for (int i = 0; i < s.len(); i++)
			add_byte(v, s[i]);
		send_value(v);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_nondigit();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = ndpd_pkg::PERCENT;
			1: c = ($urandom_range(0, 1) == 0) ? "/" : "-";
			default: begin
				do c = 8'($urandom_range(0, 255));
				while (c >= ndpd_pkg::DIGIT_LO && c <= ndpd_pkg::DIGIT_HI);
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'(ndpd_pkg::DIGIT_LO + $urandom_range(0, 9));
	endfunction

	// Mostly well-formed date shapes with random separators, sometimes
	// broken in the second literal, the tail or not at all; the rest is noise.
	function automatic void build_value(ref logic [7:0] v[$]);
		logic [7:0] sep[$];
		logic [7:0] sep2[$];
		int n;
		v.delete();
		if ($urandom_range(0, 9) < 7) begin
			n = $urandom_range(0, 2);
			repeat (n)
				add_byte(v, ($urandom_range(0, 1) == 0) ? ndpd_pkg::SPACE :
					8'(ndpd_pkg::CTRL_WS_LO + $urandom_range(0, 4)));
			repeat ($urandom_range(1, 3)) add_byte(v, pick_digit());
			n = ($urandom_range(0, 7) == 0) ?
				$urandom_range(MAX_LITERAL - 1, MAX_LITERAL + 1) : $urandom_range(1, 3);
			repeat (n) add_byte(sep, pick_nondigit());
			v = {v, sep};
			repeat ($urandom_range(1, 3)) add_byte(v, pick_digit());
			sep2 = sep;
			case ($urandom_range(0, 7))
				0: begin
					n = $urandom_range(0, sep2.size() - 1);
					sep2[n] = sep2[n] ^ 8'($urandom_range(1, 255));
				end
				1: if (sep2.size() > 1) sep2 = sep2[0:$-1];
				2: add_byte(sep2, pick_nondigit());
				default: ;
			endcase
			v = {v, sep2};
			if ($urandom_range(0, 5) != 0)
				repeat ($urandom_range(1, 2)) add_byte(v, pick_digit());
			repeat ($urandom_range(0, 3)) add_byte(v, 8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 1) == 0)
				add_byte(v, pick_digit());
			repeat ($urandom_range(1, 6)) add_byte(v, 8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		logic [7:0] v[$];
		bit mid_drained;
		board = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		bytes_sent = 0;
		tx_burst = 1'b0;
		mid_drained = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every whitespace code ahead of the first digit.
		v = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, ndpd_pkg::SPACE, "1", "/", "2", "/", "3"};
		send_value(v);
		send_text("x");
		v = '{8'hFF};
		send_value(v);
		send_text("1/2/");
		send_text("1%%2%%3");
		send_text("1%%%%%%%%2%%%%%%%%3");
		send_text("1abcdefghi2");
		v = '{"1", 8'h00, "2", 8'h00, "3"};
		send_value(v);
		send_text("1-2/3");
		send_text("1-2--3");
		send_text("1--2-3");
		send_text("1.2.3x9");
		drain();

		while (bytes_sent < 160) begin
			build_value(v);
			send_value(v);
			if (!mid_drained && bytes_sent > 120) begin
				drain();
				mid_drained = 1'b1;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/ndpd_pkg.sv
rtl/core/ndpd_queue.sv
rtl/core/ndpd_front.sv
rtl/core/ndpd_back.sv
rtl/core/numeric_date_prefix_detector.sv
sim/tb_numeric_date_prefix_detector.sv
